FILE: hdl/psfd_pkg.sv
// Shared package of the per-source flood detector: sizes, codes, request,
// result and queue types. Depends on nothing.
package psfd_pkg;

    localparam int ENTRIES   = 1024;
    localparam int HIT_SLOTS = 128;

    localparam int ENT_W   = $clog2(ENTRIES);
    localparam int USED_W  = $clog2(ENTRIES + 1);
    localparam int SLOT_W  = $clog2(HIT_SLOTS);
    localparam int CNT_W   = $clog2(HIT_SLOTS + 1);
    localparam int HADDR_W = ENT_W + SLOT_W;

    localparam logic [2:0] ST_IGNORED   = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_BLOCKED   = 3'd2;
    localparam logic [2:0] ST_COUNTED   = 3'd3;
    localparam logic [2:0] ST_NEW_BLOCK = 3'd4;

    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_TCP  = 2'd1;
    localparam logic [1:0] CLS_UDP  = 2'd2;
    localparam logic [1:0] CLS_ICMP = 2'd3;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_WINDOW    = 2'd1;
    localparam logic [1:0] REG_PORT      = 2'd2;

    localparam logic [6:0]  THRESHOLD_RST = 7'd100;
    localparam logic [15:0] WINDOW_RST    = 16'd10;
    localparam logic [15:0] PORT_RST      = 16'd80;

    typedef struct packed {
        logic [31:0] src_address;
        logic [7:0]  ip_protocol;
        logic [15:0] dest_port;
        logic [31:0] now_seconds;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  proto_class;
        logic [7:0]  recent_hits;
        logic [31:0] block_address;
    } t_result;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] now;
        logic [1:0]  cls;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_queue_head;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_ENT,
        S_WALK,
        S_APPEND
    } t_back_state;

endpackage

FILE: hdl/per_source_flood_detector.sv
// Per-source flood detector. Work per suspicious request grows with the
// number of sources compared and the stored hits of that source, and more
// when the hit store of the source is full; the source table and hit
// memories are read one entry per cycle. Ignored requests need no lookup.
// A two-entry request queue hides back-end work; the receiver cannot stall.
// Synchronous active-low reset empties the queue and the source table count.
module per_source_flood_detector
    import psfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_req        i_req,
    output logic        o_busy,
    output logic        o_res_valid,
    output t_result     o_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    // Configuration registers: writes are always taken.
    logic [6:0]  r_threshold;
    logic [15:0] r_window;
    logic [15:0] r_port;
    logic        cfg_write;

    // Queue head from the front end toward the back end.
    t_queue_head head;
    logic        pop;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_window    <= WINDOW_RST;
            r_port      <= PORT_RST;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                REG_THRESHOLD: r_threshold <= i_cfg_data[6:0];
                REG_WINDOW:    r_window    <= i_cfg_data;
                REG_PORT:      r_port      <= i_cfg_data;
                default:       r_port      <= r_port;   // hold: unused index
            endcase
        end
    end

    // Classify and enqueue each request taken while the queue is not full.
    psfd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_req          (i_req),
        .i_watched_port (r_port),
        .i_pop          (pop),
        .o_busy         (o_busy),
        .o_head         (head)
    );

    // Look up the source, age out old hits, append and decide on blocking.
    psfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_threshold (r_threshold),
        .i_window    (r_window),
        .o_pop       (pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );
endmodule

FILE: hdl/psfd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module psfd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/psfd_front.sv
// Front end: takes requests, classifies the protocol and holds them in a
// two-entry queue for the back end. Uses psfd_pkg.
module psfd_front
    import psfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_req        i_req,
    input  logic [15:0] i_watched_port,
    input  logic        i_pop,
    output logic        o_busy,
    output t_queue_head o_head
);
    t_job       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;
    logic       push;
    logic [1:0] cls;

    always_comb begin
        unique case (i_req.ip_protocol)
            PROTO_TCP:  cls = (i_req.dest_port == i_watched_port) ? CLS_TCP : CLS_NONE;
            PROTO_UDP:  cls = CLS_UDP;
            PROTO_ICMP: cls = CLS_ICMP;
            default:    cls = CLS_NONE;
        endcase
    end

    assign o_busy = (r_cnt == 2'd2);
    assign push   = i_start && !o_busy;

    always_comb begin
        n_wp  = push ? !r_wp : r_wp;
        n_rp  = i_pop ? !r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_q[r_wp] <= '{addr: i_req.src_address, now: i_req.now_seconds, cls: cls};
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.job   = r_q[r_rp];

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
endmodule

FILE: hdl/psfd_back.sv
// Back end: source lookup, hit-time compaction and blocking decision.
// Uses psfd_pkg and three psfd_ram instances.
module psfd_back
    import psfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_queue_head i_head,
    input  logic [6:0]  i_threshold,
    input  logic [15:0] i_window,
    output logic        o_pop,
    output logic        o_res_valid,
    output t_result     o_res
);
    t_back_state       r_state, n_state;
    t_job              r_job, n_job;
    logic [USED_W-1:0] r_used, n_used;
    logic [USED_W-1:0] r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [ENT_W-1:0]  r_pidx, n_pidx;
    logic [ENT_W-1:0]  r_entry, n_entry;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [CNT_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_kept, n_kept;
    logic              r_shift, n_shift;
    t_result           r_res, n_res;
    logic              r_res_v, n_res_v;

    logic              src_we;
    logic [31:0]       src_rdata;
    logic              ent_we;
    logic [CNT_W:0]    ent_wdata, ent_rdata;
    logic              hit_we;
    logic [HADDR_W-1:0] hit_waddr, hit_raddr;
    logic [31:0]       hit_wdata, hit_rdata;

    logic              match, miss, walk_done, keep, new_block;
    logic [31:0]       age;
    logic [CNT_W-1:0]  hits_after;

    assign match      = r_pend && (src_rdata == r_job.addr);
    assign miss       = !r_pend && (r_idx >= r_used);
    assign walk_done  = !r_pend && (r_rd >= r_n);
    assign age        = r_job.now - hit_rdata;
    assign keep       = r_shift || (age < {16'd0, i_window});
    assign hits_after = r_kept + 1'b1;
    assign new_block  = 16'(hits_after) > 16'(i_threshold);

    // Next state and datapath registers.
    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_used  = r_used;
        n_idx   = r_idx;
        n_pend  = r_pend;
        n_pidx  = r_pidx;
        n_entry = r_entry;
        n_n     = r_n;
        n_rd    = r_rd;
        n_kept  = r_kept;
        n_shift = r_shift;
        n_res   = r_res;
        n_res_v = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    n_job = i_head.job;
                    if (i_head.job.cls == CLS_NONE) begin
                        n_res   = '{ST_IGNORED, CLS_NONE, 8'd0, 32'd0};
                        n_res_v = 1'b1;
                    end else begin
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (match) begin
                    n_entry = r_pidx;
                    n_state = S_ENT;
                end else if (miss) begin
                    if (r_used >= USED_W'(ENTRIES)) begin
                        n_res   = '{ST_FULL, r_job.cls, 8'd0, 32'd0};
                        n_res_v = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_entry = r_used[ENT_W-1:0];
                        n_used  = r_used + 1'b1;
                        n_n     = '0;
                        n_rd    = '0;
                        n_kept  = '0;
                        n_pend  = 1'b0;
                        n_shift = 1'b0;
                        n_state = S_WALK;
                    end
                end else if (r_idx < r_used) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx[ENT_W-1:0];
                    n_idx  = r_idx + 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_ENT: begin
                if (ent_rdata[CNT_W]) begin
                    n_res   = '{ST_BLOCKED, r_job.cls, 8'd0, 32'd0};
                    n_res_v = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_n     = ent_rdata[CNT_W-1:0];
                    n_rd    = '0;
                    n_kept  = '0;
                    n_pend  = 1'b0;
                    n_shift = 1'b0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_pend && keep) begin
                    n_kept = r_kept + 1'b1;
                end
                if (walk_done) begin
                    if (!r_shift && r_kept >= CNT_W'(HIT_SLOTS)) begin
                        // store full: slide slots down by one to drop the oldest
                        n_shift = 1'b1;
                        n_n     = CNT_W'(HIT_SLOTS);
                        n_rd    = CNT_W'(1);
                        n_kept  = '0;
                    end else begin
                        n_state = S_APPEND;
                    end
                end else if (r_rd < r_n) begin
                    n_pend = 1'b1;
                    n_rd   = r_rd + 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_APPEND: begin
                n_res.status        = new_block ? ST_NEW_BLOCK : ST_COUNTED;
                n_res.proto_class   = r_job.cls;
                n_res.recent_hits   = 8'(hits_after);
                n_res.block_address = new_block ? r_job.addr : 32'd0;
                n_res_v             = 1'b1;
                n_state             = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory controls and queue pop.
    always_comb begin
        o_pop     = (r_state == S_IDLE) && i_head.valid;
        src_we    = (r_state == S_LOOK) && !match && miss
                    && (r_used < USED_W'(ENTRIES));
        ent_we    = src_we || (r_state == S_APPEND);
        ent_wdata = src_we ? '0 : {new_block, hits_after};
        hit_we    = 1'b0;
        hit_waddr = {r_entry, r_kept[SLOT_W-1:0]};
        hit_wdata = r_shift ? hit_rdata : hit_rdata;
        hit_raddr = {r_entry, r_rd[SLOT_W-1:0]};
        unique case (r_state)
            S_WALK: begin
                hit_we = r_pend && keep;
            end
            S_APPEND: begin
                hit_we    = 1'b1;
                hit_wdata = r_job.now;
            end
            default: hit_we = 1'b0;
        endcase
    end

    psfd_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (src_we),
        .i_waddr (r_used[ENT_W-1:0]),
        .i_wdata (r_job.addr),
        .i_raddr (r_idx[ENT_W-1:0]),
        .o_rdata (src_rdata)
    );

    psfd_ram #(.WIDTH(CNT_W + 1), .DEPTH(ENTRIES)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (src_we ? r_used[ENT_W-1:0] : r_entry),
        .i_wdata (ent_wdata),
        .i_raddr (r_pidx),
        .o_rdata (ent_rdata)
    );

    psfd_ram #(.WIDTH(32), .DEPTH(ENTRIES * HIT_SLOTS)) u_hit_ram (
        .i_clk   (i_clk),
        .i_we    (hit_we),
        .i_waddr (hit_waddr),
        .i_wdata (hit_wdata),
        .i_raddr (hit_raddr),
        .o_rdata (hit_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_res_v <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_res_v <= n_res_v;
            r_pend  <= n_pend;
        end
        r_job   <= n_job;
        r_idx   <= n_idx;
        r_pidx  <= n_pidx;
        r_entry <= n_entry;
        r_n     <= n_n;
        r_rd    <= n_rd;
        r_kept  <= n_kept;
        r_shift <= n_shift;
        r_res   <= n_res;
    end

    assign o_res_valid = r_res_v;
    assign o_res       = r_res;

    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_v |-> r_state == S_IDLE) else $error("result while busy");
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(ENTRIES)) else $error("table overfilled");
    a_write_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && hit_we) |-> r_kept < r_rd)
        else $error("compaction write overtook read");
endmodule

FILE: tb/sv/tb_per_source_flood_detector.sv
// Self-checking testbench of the per-source flood detector: directed and
// random packet requests, register changes, a predictor, a result checker.
// Depends on psfd_pkg and per_source_flood_detector.
module tb_per_source_flood_detector;
    import psfd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int POOL_SIZE      = 24;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    t_req        i_req;
    logic        o_busy;
    logic        o_res_valid;
    t_result     o_res;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    per_source_flood_detector i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req       (i_req),
        .o_busy      (o_busy),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state: our own copy of the registers and the source table.
    logic [6:0]  thr_q;
    logic [15:0] win_q;
    logic [15:0] port_q;
    logic [31:0] src_tab [ENTRIES];
    logic        blk_tab [ENTRIES];
    int          cnt_tab [ENTRIES];
    logic [31:0] hit_mem [ENTRIES*HIT_SLOTS];
    int          used_q;

    t_result     pending_results[$];
    int          fail_cnt;
    int          idle_cnt;
    bit          no_gaps;
    logic [31:0] clock_s;
    logic [31:0] addr_pool [POOL_SIZE];

    always #5 i_clk = ~i_clk;

    // Work out the result of one accepted packet and update the table copy.
    function automatic t_result predict_flood(t_req r);
        t_result res;
        int      e;
        int      kept;
        int      base;
        res = '0;
        if (r.ip_protocol == PROTO_TCP)
            res.proto_class = (r.dest_port == port_q) ? CLS_TCP : CLS_NONE;
        else if (r.ip_protocol == PROTO_UDP)
            res.proto_class = CLS_UDP;
        else if (r.ip_protocol == PROTO_ICMP)
            res.proto_class = CLS_ICMP;
        res.status = ST_IGNORED;
        if (res.proto_class == CLS_NONE) return res;
        e = -1;
        for (int i = 0; i < used_q; i++) begin
            if (e < 0 && src_tab[i] == r.src_address) e = i;
        end
        if (e < 0 && used_q < ENTRIES) begin
            // Add the new source with a clean flag and an empty hit list.
            e = used_q;
            src_tab[e] = r.src_address;
            blk_tab[e] = 1'b0;
            cnt_tab[e] = 0;
            used_q++;
        end
        if (e < 0) begin
            res.status = ST_FULL;
        end else if (blk_tab[e]) begin
            res.status = ST_BLOCKED;
        end else begin
            base = e * HIT_SLOTS;
            kept = 0;
            // Compact: keep hits whose age is still inside the window.
            for (int i = 0; i < cnt_tab[e]; i++) begin
                if (32'(r.now_seconds - hit_mem[base+i]) < {16'd0, win_q}) begin
                    hit_mem[base+kept] = hit_mem[base+i];
                    kept++;
                end
            end
            if (kept >= HIT_SLOTS) begin
                // Discard the oldest hit to make room.
                for (int i = 0; i < HIT_SLOTS - 1; i++)
                    hit_mem[base+i] = hit_mem[base+i+1];
                kept = HIT_SLOTS - 1;
            end
            hit_mem[base+kept] = r.now_seconds;
            kept++;
            cnt_tab[e] = kept;
            res.recent_hits = 8'(kept);
            if (kept > int'(thr_q)) begin
                blk_tab[e] = 1'b1;
                res.status = ST_NEW_BLOCK;
                res.block_address = r.src_address;
            end else begin
                res.status = ST_COUNTED;
            end
        end
        return res;
    endfunction

    // Check each result against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_res);
                fail_cnt++;
            end else begin
                t_result want;
                want = pending_results.pop_front();
                if (o_res.status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, o_res.status);
                    fail_cnt++;
                end
                if (o_res.proto_class !== want.proto_class) begin
                    $display("%0t: proto_class exp %0d got %0d", $time,
                             want.proto_class, o_res.proto_class);
                    fail_cnt++;
                end
                if (o_res.recent_hits !== want.recent_hits) begin
                    $display("%0t: recent_hits exp %0d got %0d", $time,
                             want.recent_hits, o_res.recent_hits);
                    fail_cnt++;
                end
                if (o_res.block_address !== want.block_address) begin
                    $display("%0t: block_address exp %h got %h", $time,
                             want.block_address, o_res.block_address);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no request, result or write moves.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_res_valid || (i_cfg_valid && o_cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Send one request; all tasks start and end at a falling edge.
    task automatic send_req(input t_req r);
        if (!no_gaps && $urandom_range(0, 99) < 11) begin
            i_start = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_start = 1'b1;
        i_req   = r;
        do @(posedge i_clk); while (o_busy);
        pending_results.push_back(predict_flood(r));
        @(negedge i_clk);
    endtask

    task automatic send_pkt(input logic [31:0] a, input logic [7:0] p,
                            input logic [15:0] dp, input logic [31:0] t);
        t_req r;
        r.src_address = a;
        r.ip_protocol = p;
        r.dest_port   = dp;
        r.now_seconds = t;
        send_req(r);
    endtask

    // Hold off until every predicted result has arrived, then settle.
    task automatic drain;
        i_start = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        drain();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_THRESHOLD: thr_q  = val[6:0];
            REG_WINDOW:    win_q  = val;
            REG_PORT:      port_q = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Field extremes, every protocol class, time wrap, ignored packets.
    task automatic test_directed;
        send_pkt(32'h0000_0000, PROTO_TCP, 16'd80, 32'h0000_0000);
        send_pkt(32'hFFFF_FFFF, PROTO_UDP, 16'hFFFF, 32'hFFFF_FFFF);
        send_pkt(32'hFFFF_FFFF, PROTO_ICMP, 16'h0000, 32'hFFFF_FFFE);
        send_pkt(32'hFFFF_FFFF, PROTO_TCP, 16'd80, 32'h0000_0003); // across wrap
        send_pkt(32'hFFFF_FFFF, PROTO_TCP, 16'd80, 32'h0000_0010); // aged out
        send_pkt(32'h1234_5678, PROTO_TCP, 16'd81, 32'd5);        // wrong port
        send_pkt(32'h1234_5678, 8'd0, 16'd80, 32'd5);
        send_pkt(32'h1234_5678, 8'hFF, 16'hFFFF, 32'd5);
        send_pkt(32'hAAAA_5555, 8'd2, 16'h5555, 32'hAAAA_AAAA);
        send_pkt(32'h5555_AAAA, PROTO_ICMP, 16'hAAAA, 32'h5555_5555);
        write_reg(REG_PORT, 16'hFFFF);
        send_pkt(32'h0000_0000, PROTO_TCP, 16'hFFFF, 32'd1);
        send_pkt(32'h0000_0000, PROTO_TCP, 16'd80, 32'd1);
        write_reg(REG_PORT, 16'h0000);
        send_pkt(32'h0000_0000, PROTO_TCP, 16'h0000, 32'd2);
    endtask

    // Threshold zero: the first counted hit of each source blocks it; later ones see blocked.
    task automatic test_threshold_zero;
        write_reg(REG_THRESHOLD, 16'd0);
        send_pkt(32'hC0A8_0001, PROTO_UDP, 16'd0, 32'd100);
        send_pkt(32'hC0A8_0001, PROTO_ICMP, 16'd0, 32'd101);
        send_pkt(32'hC0A8_0002, PROTO_TCP, 16'h0000, 32'd102);
    endtask

    // Window zero: no stored hit ever counts.
    task automatic test_window_zero;
        write_reg(REG_THRESHOLD, 16'd1);
        write_reg(REG_WINDOW, 16'd0);
        repeat (3) send_pkt(32'hC0A8_0003, PROTO_UDP, 16'd0, 32'd500);
    endtask

    // Largest threshold and window: 128 hits in a burst block the source.
    task automatic test_max_threshold;
        write_reg(REG_THRESHOLD, 16'd127);
        write_reg(REG_WINDOW, 16'hFFFF);
        for (int i = 0; i < 129; i++)
            send_pkt(32'h0A00_0001, PROTO_ICMP, 16'(i), 32'(1000 + i / 4));
    endtask

    function automatic t_req rand_pkt();
        t_req r;
        int   pick;
        r.src_address = ($urandom_range(0, 9) == 0) ? $urandom()
                      : addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        r.dest_port = 16'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            r.ip_protocol = PROTO_TCP;
            if (pick < 18) r.dest_port = port_q;
        end else if (pick < 60) begin
            r.ip_protocol = PROTO_UDP;
        end else if (pick < 85) begin
            r.ip_protocol = PROTO_ICMP;
        end else begin
            r.ip_protocol = 8'($urandom());
        end
        if ($urandom_range(0, 49) == 0)
            clock_s = clock_s + $urandom_range(0, 200);
        else
            clock_s = clock_s + $urandom_range(0, 2);
        r.now_seconds = clock_s;
        return r;
    endfunction

    // Random phases over a small pool of sources with short windows.
    task automatic test_random;
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_THRESHOLD, 16'($urandom_range(1, 12)));
            write_reg(REG_WINDOW, 16'($urandom_range(1, 40)));
            write_reg(REG_PORT, (ph % 2 == 0) ? 16'($urandom()) : 16'd443);
            clock_s = (ph == 3) ? 32'hFFFF_FF00 : $urandom();
            // New sources keep arriving with fresh, unblocked entries.
            foreach (addr_pool[k]) addr_pool[k] = $urandom();
            no_gaps = (ph == 5);
            for (int n = 0; n < 90; n++) begin
                send_req(rand_pkt());
                // Pause the sender until everything is back once per phase.
                if (n == 45) drain();
            end
            no_gaps = 1'b0;
        end
        write_reg(REG_THRESHOLD, 16'd127);
        write_reg(REG_WINDOW, 16'hFFFF);
        for (int n = 0; n < 40; n++) send_req(rand_pkt());
    endtask

    // Fill the table with distinct sources, then send new sources, a known one and an ignored packet.
    task automatic test_table_full;
        logic [31:0] a;
        write_reg(REG_THRESHOLD, 16'd100);
        write_reg(REG_WINDOW, 16'd10);
        write_reg(REG_PORT, 16'd80);
        a = 32'h8000_0000;
        while (used_q < ENTRIES) begin
            a = a + 32'd7;
            send_pkt(a, PROTO_UDP, 16'd0, 32'd9000);
        end
        send_pkt(32'h7FFF_FFFF, PROTO_ICMP, 16'd0, 32'd9001);
        send_pkt(32'h7FFF_FFFE, PROTO_TCP, 16'd80, 32'd9002);
        send_pkt(a, PROTO_UDP, 16'd0, 32'd9003);
        send_pkt(32'h7FFF_FFFD, 8'd99, 16'd80, 32'd9004);
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_THRESHOLD;
        i_cfg_data  = '0;
        thr_q       = THRESHOLD_RST;
        win_q       = WINDOW_RST;
        port_q      = PORT_RST;
        used_q      = 0;
        fail_cnt    = 0;
        idle_cnt    = 0;
        no_gaps     = 1'b0;
        clock_s     = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_threshold_zero();
        test_window_zero();
        test_max_threshold();
        test_random();
        test_table_full();

        drain();
        repeat (20) @(negedge i_clk);
        if (fail_cnt == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/psfd_pkg.sv
hdl/psfd_ram.sv
hdl/psfd_front.sv
hdl/psfd_back.sv
hdl/per_source_flood_detector.sv
tb/sv/tb_per_source_flood_detector.sv
